// ===== src/pfb_pkg.sv =====
`default_nettype none
package pfb_pkg;

  localparam int BRANCHES    = 128;
  localparam int TAPS        = 26;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int SUM_BITS    = 36;

  localparam int LINE_WORDS = BRANCHES * TAPS;
  localparam int ADDR_W     = $clog2(LINE_WORDS);
  localparam int BRANCH_W   = $clog2(BRANCHES);
  localparam int TAP_W      = $clog2(TAPS);
  localparam int STEP_W     = $clog2(TAPS + 2);
  localparam int PROD_W     = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W      = (PROD_W > SUM_BITS) ? PROD_W : SUM_BITS;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } pfb_op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } pfb_state_e;

  typedef struct packed {
    logic              load;
    logic              start;
    logic [TAP_W-1:0]  rd_tap;
    logic              mac_en;
    logic [TAP_W-1:0]  wr_tap;
    logic              acc_en;
    logic              finish;
    logic              clr_en;
    logic [ADDR_W-1:0] clr_addr;
  } pfb_cmd_t;

  typedef struct packed {
    logic out_busy;
  } pfb_status_t;

endpackage
`default_nettype wire

// ===== src/polyphase_fir_bank.sv =====
`default_nettype none
// Sample beat: the result is valid once the single MAC per stream has walked the
// branch's taps out of the delay and coefficient RAMs; no new beat is taken until
// the block is idle again, which waits while an earlier result is still held.
// Coefficient load beat: writes the coefficient RAM when branch and tap are in range, no result.
// Reset: in_ready_o stays low while all BRANCHES*TAPS (3328) words of the delay RAM are zeroed.
module polyphase_fir_bank (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic                                  opcode_i,
  input  wire logic        [pfb_pkg::BRANCH_W-1:0]    coef_branch_i,
  input  wire logic        [pfb_pkg::TAP_W-1:0]       coef_tap_i,
  input  wire logic signed [pfb_pkg::COEF_BITS-1:0]   coef_value_i,
  input  wire logic signed [pfb_pkg::SAMPLE_BITS-1:0] sample_re_i,
  input  wire logic signed [pfb_pkg::SAMPLE_BITS-1:0] sample_im_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic             [pfb_pkg::BRANCH_W-1:0]    branch_index_o,
  output logic                                        frame_end_o,
  output logic signed      [pfb_pkg::SUM_BITS-1:0]    sum_re_o,
  output logic signed      [pfb_pkg::SUM_BITS-1:0]    sum_im_o
);
  import pfb_pkg::*;

  pfb_cmd_t    cmd;
  pfb_status_t status;

  pfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pfb_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .coef_branch_i  (coef_branch_i),
    .coef_tap_i     (coef_tap_i),
    .coef_value_i   (coef_value_i),
    .sample_re_i    (sample_re_i),
    .sample_im_i    (sample_im_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .branch_index_o (branch_index_o),
    .frame_end_o    (frame_end_o),
    .sum_re_o       (sum_re_o),
    .sum_im_o       (sum_im_o)
  );

endmodule
`default_nettype wire

// ===== src/pfb_ram.sv =====
`default_nettype none
module pfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== src/pfb_ctrl.sv =====
`default_nettype none
module pfb_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                opcode_i,
  input  wire pfb_pkg::pfb_status_t status_i,
  output pfb_pkg::pfb_cmd_t        cmd_o
);
  import pfb_pkg::*;

  pfb_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              accept;

  assign accept = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(LINE_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (opcode_i == OP_SAMPLE)) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(TAPS + 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.clr_addr = clr_q;
    cmd_o.rd_tap   = TAP_W'(step_q);
    cmd_o.wr_tap   = TAP_W'(step_q - STEP_W'(1));
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i && (opcode_i == OP_LOAD);
        cmd_o.start = in_valid_i && (opcode_i == OP_SAMPLE);
      end
      ST_RUN: begin
        // each tap is read, then multiplied, then accumulated, each step registered
        cmd_o.mac_en = (step_q >= STEP_W'(1)) && (step_q <= STEP_W'(TAPS));
        cmd_o.acc_en = (step_q >= STEP_W'(2));
      end
      ST_DONE: begin
        cmd_o.finish = !status_i.out_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      step_q  <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      clr_q   <= clr_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/pfb_datapath.sv =====
`default_nettype none
module pfb_datapath (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire pfb_pkg::pfb_cmd_t                     cmd_i,
  output pfb_pkg::pfb_status_t                       status_o,
  input  wire logic        [pfb_pkg::BRANCH_W-1:0]    coef_branch_i,
  input  wire logic        [pfb_pkg::TAP_W-1:0]       coef_tap_i,
  input  wire logic signed [pfb_pkg::COEF_BITS-1:0]   coef_value_i,
  input  wire logic signed [pfb_pkg::SAMPLE_BITS-1:0] sample_re_i,
  input  wire logic signed [pfb_pkg::SAMPLE_BITS-1:0] sample_im_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic             [pfb_pkg::BRANCH_W-1:0]    branch_index_o,
  output logic                                        frame_end_o,
  output logic signed      [pfb_pkg::SUM_BITS-1:0]    sum_re_o,
  output logic signed      [pfb_pkg::SUM_BITS-1:0]    sum_im_o
);
  import pfb_pkg::*;

  logic [BRANCH_W-1:0] branch_q;
  logic                out_valid_q;
  logic [ADDR_W-1:0]   base_q;

  logic signed [SAMPLE_BITS-1:0] shift_re_q, shift_im_q;
  logic signed [PROD_W-1:0]      prod_re_q, prod_im_q;
  logic signed [ACC_W-1:0]       acc_re_q, acc_im_q;

  logic                     last_branch;
  logic                     coef_in_range;
  logic                     coef_we;
  logic [ADDR_W-1:0]        coef_waddr;
  logic [ADDR_W-1:0]        rd_addr;
  logic signed [COEF_BITS-1:0] coef_rd;
  logic                     dly_we;
  logic [ADDR_W-1:0]        dly_waddr;
  logic [2*SAMPLE_BITS-1:0] dly_wdata;
  logic [2*SAMPLE_BITS-1:0] dly_rd;

  assign last_branch = (branch_q == BRANCH_W'(BRANCHES - 1));

  assign coef_in_range = ({1'b0, coef_branch_i} < (BRANCH_W + 1)'(BRANCHES)) &&
                         ({1'b0, coef_tap_i} < (TAP_W + 1)'(TAPS));
  assign coef_we    = cmd_i.load && coef_in_range;
  assign coef_waddr = ADDR_W'(32'(coef_branch_i) * TAPS + 32'(coef_tap_i));

  assign rd_addr = base_q + ADDR_W'(cmd_i.rd_tap);

  // clearing pass owns the write port until the block goes idle
  always_comb begin
    dly_we    = cmd_i.clr_en || cmd_i.mac_en;
    dly_waddr = cmd_i.clr_en ? cmd_i.clr_addr : (base_q + ADDR_W'(cmd_i.wr_tap));
    dly_wdata = cmd_i.clr_en ? '0 : {shift_re_q, shift_im_q};
  end

  pfb_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (LINE_WORDS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_value_i),
    .raddr_i (rd_addr),
    .rdata_o (coef_rd)
  );

  pfb_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (LINE_WORDS)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (dly_we),
    .waddr_i (dly_waddr),
    .wdata_i (dly_wdata),
    .raddr_i (rd_addr),
    .rdata_o (dly_rd)
  );

  // shift_q holds the new tap value: the sample, then each old tap one place down
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      base_q     <= ADDR_W'(32'(branch_q) * TAPS);
      shift_re_q <= sample_re_i;
      shift_im_q <= sample_im_i;
      acc_re_q   <= '0;
      acc_im_q   <= '0;
    end else begin
      if (cmd_i.mac_en) begin
        prod_re_q  <= shift_re_q * coef_rd;
        prod_im_q  <= shift_im_q * coef_rd;
        shift_re_q <= dly_rd[2*SAMPLE_BITS-1:SAMPLE_BITS];
        shift_im_q <= dly_rd[SAMPLE_BITS-1:0];
      end
      if (cmd_i.acc_en) begin
        acc_re_q <= acc_re_q + ACC_W'(prod_re_q);
        acc_im_q <= acc_im_q + ACC_W'(prod_im_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      branch_index_o <= branch_q;
      frame_end_o    <= last_branch;
      sum_re_o       <= acc_re_q[SUM_BITS-1:0];
      sum_im_o       <= acc_im_q[SUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      branch_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        branch_q    <= last_branch ? '0 : branch_q + BRANCH_W'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

endmodule
`default_nettype wire
